[design/sfcs_pkg.sv]
// Package of types, opcodes and constants shared by the SPI flash command sequencer.
package sfcs_pkg;

  localparam int unsigned BUFFER_BYTES = 260;
  localparam int unsigned PAGE_BYTES   = 256;

  localparam int unsigned LEN_W = 9;
  localparam int unsigned LEN_MASK = (1 << LEN_W) - 1;

  localparam logic [LEN_W-1:0] LEN_READ   = LEN_W'((PAGE_BYTES + 4) & LEN_MASK);
  localparam logic [LEN_W-1:0] LEN_WRITE  = LEN_W'(BUFFER_BYTES & LEN_MASK);
  localparam logic [LEN_W-1:0] LEN_ERASE  = LEN_W'(4);
  localparam logic [LEN_W-1:0] LEN_STATUS = LEN_W'(2);
  localparam logic [LEN_W-1:0] LEN_JEDEC  = LEN_W'(4);
  localparam logic [LEN_W-1:0] LEN_SHORT  = LEN_W'(1);

  localparam logic [7:0] CMD_WRITE  = 8'h02;
  localparam logic [7:0] CMD_READ   = 8'h03;
  localparam logic [7:0] CMD_STATUS = 8'h05;
  localparam logic [7:0] CMD_WREN   = 8'h06;
  localparam logic [7:0] CMD_ERASE  = 8'h20;
  localparam logic [7:0] CMD_JEDEC  = 8'h9f;
  localparam logic [7:0] CMD_UP     = 8'hab;
  localparam logic [7:0] CMD_DOWN   = 8'hb9;

  localparam logic [7:0] SR_WEL = 8'h01 << 1;
  localparam logic [7:0] SR_WIP = 8'h01 << 0;

  localparam logic [5:0] PH_WEL_ERASE   = 6'h01;
  localparam logic [5:0] PH_WEL_WRITE   = 6'h02;
  localparam logic [5:0] PH_WAIT_ERASE  = 6'h04;
  localparam logic [5:0] PH_WAIT_WRITE  = 6'h08;
  localparam logic [5:0] PH_START_WRITE = 6'h10;
  localparam logic [5:0] PH_START_ERASE = 6'h20;

  typedef enum logic [3:0] {
    REQ_READ      = 4'd0,
    REQ_WRITE     = 4'd1,
    REQ_ERASE     = 4'd2,
    REQ_STATUS    = 4'd3,
    REQ_JEDEC     = 4'd4,
    REQ_POWERUP   = 4'd5,
    REQ_POWERDOWN = 4'd6,
    REQ_TICK      = 4'd7,
    REQ_XFER_DONE = 4'd8,
    REQ_POLL      = 4'd9
  } request_e;

  typedef enum logic [3:0] {
    EV_NONE       = 4'd0,
    EV_SEND       = 4'd1,
    EV_REJECTED   = 4'd2,
    EV_READ_DONE  = 4'd3,
    EV_STATUS     = 4'd4,
    EV_WRITE_DONE = 4'd5,
    EV_ERASE_DONE = 4'd6,
    EV_ID         = 4'd7,
    EV_UP         = 4'd8,
    EV_DOWN       = 4'd9
  } event_e;

  typedef struct packed {
    logic [3:0]  operation;
    logic [23:0] flash_address;
    logic [7:0]  rx_byte1;
    logic [7:0]  rx_byte2;
    logic [7:0]  rx_byte3;
  } in_word_t;

  typedef struct packed {
    logic [3:0]       event_kind;
    logic [7:0]       command_opcode;
    logic [23:0]      command_address;
    logic [LEN_W-1:0] transfer_length;
    logic [7:0]       status_value;
    logic [7:0]       manufacturer_id;
    logic [15:0]      device_id;
    logic             creset_level;
    logic             last_result;
  } out_word_t;

  typedef struct packed {
    logic [7:0]  current_opcode;
    logic        bus_busy;
    logic        parked_valid;
    logic        parked_is_write;
    logic [23:0] parked_address;
    logic [5:0]  phase_flags;
    logic        poll_timer_on;
    logic        tick_seen;
    logic        reset_pin;
  } seq_state_t;

  typedef struct packed {
    logic [1:0] count;
    out_word_t  first;
    out_word_t  second;
  } result_pair_t;

endpackage

[design/sfcs_core.sv]
// Sequencer state and the single-pass decision logic that turns one word into its results.
module sfcs_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 step_i,
  input  sfcs_pkg::in_word_t   word_i,
  output sfcs_pkg::result_pair_t res_o
);
  import sfcs_pkg::*;

  seq_state_t st_q, st_d;
  out_word_t  r0, r1;
  logic [1:0] n;

  function automatic out_word_t mk_event(logic [3:0] kind);
    out_word_t w;
    w = '0;
    w.event_kind = kind;
    return w;
  endfunction

  function automatic out_word_t mk_send(logic [7:0] opc, logic [23:0] addr,
                                       logic [LEN_W-1:0] len);
    out_word_t w;
    w = '0;
    w.event_kind      = EV_SEND;
    w.command_opcode  = opc;
    w.command_address = addr;
    w.transfer_length = len;
    return w;
  endfunction

  always_comb begin
    st_d = st_q;
    r0   = '0;
    r1   = '0;
    n    = 2'd0;
    case (word_i.operation)
      REQ_READ, REQ_STATUS, REQ_JEDEC, REQ_POWERUP, REQ_POWERDOWN: begin
        if (st_q.bus_busy) begin
          r0 = mk_event(EV_REJECTED);
        end else begin
          st_d.bus_busy = 1'b1;
          case (word_i.operation)
            REQ_READ:   r0 = mk_send(CMD_READ, word_i.flash_address, LEN_READ);
            REQ_STATUS: r0 = mk_send(CMD_STATUS, '0, LEN_STATUS);
            REQ_JEDEC:  r0 = mk_send(CMD_JEDEC, '0, LEN_JEDEC);
            REQ_POWERUP: begin
              st_d.reset_pin = 1'b0;
              r0 = mk_send(CMD_UP, '0, LEN_SHORT);
            end
            default:    r0 = mk_send(CMD_DOWN, '0, LEN_SHORT);
          endcase
          st_d.current_opcode = r0.command_opcode;
        end
        n = 2'd1;
      end
      REQ_WRITE, REQ_ERASE: begin
        if (st_q.bus_busy || st_q.parked_valid) begin
          r0 = mk_event(EV_REJECTED);
        end else begin
          st_d.parked_valid    = 1'b1;
          st_d.parked_is_write = (word_i.operation == REQ_WRITE);
          st_d.parked_address  = word_i.flash_address;
          st_d.phase_flags     = st_q.phase_flags |
              ((word_i.operation == REQ_WRITE) ? PH_WEL_WRITE : PH_WEL_ERASE);
          st_d.bus_busy        = 1'b1;
          st_d.current_opcode  = CMD_WREN;
          r0 = mk_send(CMD_WREN, '0, LEN_SHORT);
        end
        n = 2'd1;
      end
      REQ_TICK: begin
        if (st_q.poll_timer_on) begin
          st_d.tick_seen = 1'b1;
        end
      end
      REQ_XFER_DONE: begin
        if (st_q.bus_busy) begin
          st_d.bus_busy = 1'b0;
          case (st_q.current_opcode)
            CMD_READ: begin
              r0 = mk_event(EV_READ_DONE);
              n  = 2'd1;
            end
            CMD_STATUS: begin
              r1 = mk_event(EV_STATUS);
              r1.status_value = word_i.rx_byte1;
              n  = 2'd1;
              if (|(st_q.phase_flags & PH_WEL_ERASE) && |(word_i.rx_byte1 & SR_WEL)) begin
                st_d.phase_flags = (st_q.phase_flags & ~PH_WEL_ERASE) | PH_START_ERASE;
              end else if (|(st_q.phase_flags & PH_WEL_WRITE) &&
                           |(word_i.rx_byte1 & SR_WEL)) begin
                st_d.phase_flags = (st_q.phase_flags & ~PH_WEL_WRITE) | PH_START_WRITE;
              end else if (|(st_q.phase_flags & PH_WAIT_ERASE) &&
                           !(|(word_i.rx_byte1 & SR_WIP))) begin
                st_d.phase_flags   = st_q.phase_flags & ~PH_WAIT_ERASE;
                st_d.poll_timer_on = 1'b0;
                st_d.parked_valid  = 1'b0;
                r0 = mk_event(EV_ERASE_DONE);
                n  = 2'd2;
              end else if (|(st_q.phase_flags & PH_WAIT_WRITE) &&
                           !(|(word_i.rx_byte1 & SR_WIP))) begin
                st_d.phase_flags   = st_q.phase_flags & ~PH_WAIT_WRITE;
                st_d.poll_timer_on = 1'b0;
                st_d.parked_valid  = 1'b0;
                r0 = mk_event(EV_WRITE_DONE);
                n  = 2'd2;
              end
              if (n == 2'd1) begin
                r0 = r1;
              end
            end
            CMD_WREN: begin
              st_d.poll_timer_on = 1'b1;
            end
            CMD_JEDEC: begin
              r0 = mk_event(EV_ID);
              r0.manufacturer_id = word_i.rx_byte1;
              r0.device_id       = {word_i.rx_byte2, word_i.rx_byte3};
              n  = 2'd1;
            end
            CMD_UP: begin
              r0 = mk_event(EV_UP);
              n  = 2'd1;
            end
            CMD_DOWN: begin
              st_d.reset_pin = 1'b1;
              r0 = mk_event(EV_DOWN);
              n  = 2'd1;
            end
            default: begin
            end
          endcase
        end
      end
      REQ_POLL: begin
        if (|(st_q.phase_flags & (PH_START_ERASE | PH_START_WRITE))) begin
          if (!st_q.bus_busy) begin
            st_d.bus_busy = 1'b1;
            n = 2'd1;
            if (|(st_q.phase_flags & PH_START_ERASE)) begin
              st_d.phase_flags    = (st_q.phase_flags & ~PH_START_ERASE) | PH_WAIT_ERASE;
              st_d.current_opcode = CMD_ERASE;
              r0 = mk_send(CMD_ERASE, st_q.parked_address, LEN_ERASE);
            end else begin
              st_d.phase_flags    = (st_q.phase_flags & ~PH_START_WRITE) | PH_WAIT_WRITE;
              st_d.current_opcode = CMD_WRITE;
              r0 = mk_send(CMD_WRITE, st_q.parked_address, LEN_WRITE);
            end
          end
        end else if (st_q.tick_seen) begin
          st_d.tick_seen = 1'b0;
          if (!st_q.bus_busy) begin
            st_d.bus_busy       = 1'b1;
            st_d.current_opcode = CMD_STATUS;
            r0 = mk_send(CMD_STATUS, '0, LEN_STATUS);
            n  = 2'd1;
          end
        end
      end
      default: begin
      end
    endcase

    if (n == 2'd0) begin
      r0 = mk_event(EV_NONE);
      n  = 2'd1;
    end
    r0.creset_level = st_d.reset_pin;
    r1.creset_level = st_d.reset_pin;
    r0.last_result  = (n == 2'd1);
    r1.last_result  = 1'b1;

    res_o.count  = step_i ? n : 2'd0;
    res_o.first  = r0;
    res_o.second = r1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= '{reset_pin: 1'b1, default: '0};
    end else if (step_i) begin
      st_q <= st_d;
    end
  end

endmodule

[design/sfcs_out_queue.sv]
// Four-entry result queue; takes up to two words a cycle, pops one when ready.
module sfcs_out_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  sfcs_pkg::result_pair_t push_i,
  output logic                   room_o,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output sfcs_pkg::out_word_t    out_word_o
);
  import sfcs_pkg::*;

  out_word_t  mem_q [4];
  logic [1:0] wr_q, rd_q;
  logic [2:0] cnt_q, cnt_d;
  logic       pop;

  assign pop         = out_valid_o && out_ready_i;
  assign out_valid_o = (cnt_q != 3'd0);
  assign out_word_o  = mem_q[rd_q];
  assign room_o      = (cnt_q <= 3'd2);
  assign cnt_d       = cnt_q + {1'b0, push_i.count} - {2'b00, pop};

  always_ff @(posedge clk_i) begin
    if (push_i.count != 2'd0) begin
      mem_q[wr_q] <= push_i.first;
    end
    if (push_i.count == 2'd2) begin
      mem_q[wr_q + 2'd1] <= push_i.second;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_q + push_i.count;
      rd_q  <= rd_q + {1'b0, pop};
      cnt_q <= cnt_d;
    end
  end

endmodule

[design/spi_flash_command_sequencer_top.sv]
// Top level of the SPI flash command sequencer: input register, decision core and result queue.
// One word is accepted per clock cycle while the queue has room. An accepted word is held in the input
// register until the queue has room, is then resolved in a single pass against the sequencer state,
// and its one or two results are written into a four-entry queue, from which the first is offered.
// A finished status read that completes a write or erase yields two results, so the output
// side hands out two words for it; the input keeps flowing while the queue has room for two words.
module spi_flash_command_sequencer_top (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_ready_o,
  input  sfcs_pkg::in_word_t  in_word_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output sfcs_pkg::out_word_t out_word_o
);
  import sfcs_pkg::*;

  in_word_t     in_q;
  logic         in_valid_q;
  logic         room;
  logic         step;
  result_pair_t res;

  assign step       = in_valid_q && room;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_word_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  sfcs_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .word_i (in_q),
    .res_o  (res)
  );

  sfcs_out_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (res),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_word_o  (out_word_o)
  );

endmodule

[design/sfcs_checker.sv]
// Port-level checks of the SPI flash command sequencer and their binding to the top level.
module sfcs_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                out_valid_o,
  input logic                out_ready_i,
  input sfcs_pkg::out_word_t out_word_o
);
  import sfcs_pkg::*;

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o)
    else $error("Result word withdrawn before it was taken.");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> $stable(out_word_o))
    else $error("Result word changed while stalled.");

  a_none_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.event_kind == EV_NONE |-> out_word_o.last_result)
    else $error("An empty result was not the final word of its request.");

  a_done_not_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && (out_word_o.event_kind == EV_WRITE_DONE ||
                    out_word_o.event_kind == EV_ERASE_DONE) |-> !out_word_o.last_result)
    else $error("A completion was not followed by its status word.");

  a_opcode_only_send: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_word_o.event_kind != EV_SEND |-> out_word_o.command_opcode == 8'h00)
    else $error("An opcode was reported on a word that starts no transfer.");

endmodule

bind spi_flash_command_sequencer_top sfcs_checker u_sfcs_checker (.*);
